// File: hdl/gdq_pkg.sv
// ----------------------------------------------------------------------------
// gdq_pkg
// Shared widths and types of the group dequantizing dot product.
// ----------------------------------------------------------------------------
package gdq_pkg;

    localparam int LANES    = 4;
    localparam int WEIGHT_W = 8;
    localparam int ACT_W    = 16;
    localparam int SCALE_W  = 16;
    localparam int ZERO_W   = 16;
    localparam int DIFF_W   = 17;
    localparam int SCALED_W = 2 * DIFF_W;
    localparam int TERM_W   = SCALED_W + ACT_W;
    localparam int SUM_W    = 64;
    localparam int IN_W     = LANES * (WEIGHT_W + ACT_W) + SCALE_W + ZERO_W;

    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [SUM_W-1:0]  t_sum;

    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

endpackage

// File: hdl/gdq_lane.sv
// ----------------------------------------------------------------------------
// gdq_lane
// One lane: (weight * 256 - zero) * scale, then times activation, two stages.
// ----------------------------------------------------------------------------
module gdq_lane import gdq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [WEIGHT_W-1:0]       i_weight,
    input  logic signed [ACT_W-1:0]   i_act,
    input  logic [SCALE_W-1:0]        i_scale,
    input  logic [ZERO_W-1:0]         i_zero,
    output t_term                     o_term
);

    logic signed [DIFF_W-1:0]   n_diff;
    logic signed [SCALED_W-1:0] r_scaled;
    logic signed [ACT_W-1:0]    r_act;
    t_term                      r_term;

    assign n_diff = $signed({1'b0, i_weight, 8'h00}) - $signed({1'b0, i_zero});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scaled <= n_diff * $signed({1'b0, i_scale});
            r_act    <= i_act;
            r_term   <= r_scaled * r_act;
        end
    end

    assign o_term = r_term;

endmodule

// File: hdl/gdq_merge.sv
// ----------------------------------------------------------------------------
// gdq_merge
// Sum the lane terms into the row accumulator and hold the row result.
// ----------------------------------------------------------------------------
module gdq_merge import gdq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  t_stage_ctl  i_ctl,
    input  t_term       i_terms [LANES],
    input  logic        i_m_tready,
    output logic        o_valid,
    output t_sum        o_data
);

    t_sum r_acc;
    t_sum r_out;
    logic r_out_valid;
    t_sum n_sum;
    t_sum n_acc;

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            n_sum = n_sum + SUM_W'(i_terms[i]);
        end
        n_acc = r_acc + n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_adv && i_ctl.valid) begin
                r_acc <= i_ctl.last ? '0 : n_acc;
            end
            if (i_adv && i_ctl.valid && i_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctl.valid && i_ctl.last) begin
            r_out <= n_acc;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// File: hdl/group_dequant_dot_product_top.sv
// ----------------------------------------------------------------------------
// group_dequant_dot_product_top
// Quantized row dot product with group scale and zero point, four lanes.
// ----------------------------------------------------------------------------
// Path: the last word of a row passes the lane's scaled and term registers, then the output register.
// Throughput: one word per cycle; the pipeline stalls only while a result
// waits in the output register and the master side is not ready.
// Reset: synchronous, active low; clears the accumulator and all valid flags.
// ----------------------------------------------------------------------------
module group_dequant_dot_product_top import gdq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    // weight_a, weight_b, weight_c, weight_d, act_a, act_b, act_c, act_d,
    // group_scale, group_zero
    input  logic [IN_W-1:0] i_s_tdata,
    input  logic            i_s_tlast,   // last_of_row
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [SUM_W-1:0] o_m_tdata   // row_sum
);

    localparam int ACT_BASE   = LANES * WEIGHT_W;
    localparam int SCALE_BASE = ACT_BASE + LANES * ACT_W;
    localparam int ZERO_BASE  = SCALE_BASE + SCALE_W;

    logic       w_adv;
    t_stage_ctl r_st1;
    t_stage_ctl r_st2;
    t_term      w_terms [LANES];
    t_sum       w_sum;

    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st1 <= '0;
            r_st2 <= '0;
        end else if (w_adv) begin
            r_st1.valid <= i_s_tvalid;
            r_st1.last  <= i_s_tlast;
            r_st2       <= r_st1;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        gdq_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_adv),
            .i_weight (i_s_tdata[g*WEIGHT_W +: WEIGHT_W]),
            .i_act    ($signed(i_s_tdata[ACT_BASE + g*ACT_W +: ACT_W])),
            .i_scale  (i_s_tdata[SCALE_BASE +: SCALE_W]),
            .i_zero   (i_s_tdata[ZERO_BASE +: ZERO_W]),
            .o_term   (w_terms[g])
        );
    end

    gdq_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_ctl      (r_st2),
        .i_terms    (w_terms),
        .i_m_tready (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_data     (w_sum)
    );

    assign o_m_tdata = w_sum;

endmodule

// File: hdl/gdq_checker.sv
// ----------------------------------------------------------------------------
// gdq_checker
// Port-level checks of the dot product block, bound to the top level.
// ----------------------------------------------------------------------------
module gdq_checker import gdq_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             i_s_tlast,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [SUM_W-1:0] o_m_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not track output register");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output word changed");

    a_no_result_without_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_s_tvalid && o_s_tready && i_s_tlast) && !o_m_tvalid
        ##1 !(i_s_tvalid && o_s_tready && i_s_tlast) && !o_m_tvalid
        ##1 !o_m_tvalid |=> !o_m_tvalid)
        else $error("result without a last word in flight");

endmodule

bind group_dequant_dot_product_top gdq_checker u_gdq_checker (.*);
